[sv/plcl_pkg.sv]
// Package for the piecewise-linear curve lookup block.
// Holds mode and status codes, operand widths and the multiply-divide request type.
// No dependencies.
package plcl_pkg;

	localparam int ENTRIES_DEFAULT   = 256;
	localparam int FRAC_BITS_DEFAULT = 16;

	localparam int DW  = 32; // data word
	localparam int OPW = 34; // multiply-divide operand width
	localparam int QW  = 42; // signed capped quotient width

	localparam logic [2:0] MODE_CLEAR    = 3'd0;
	localparam logic [2:0] MODE_LOAD     = 3'd1;
	localparam logic [2:0] MODE_LOOKUP   = 3'd2;
	localparam logic [2:0] MODE_LOOKUP_X = 3'd3;
	localparam logic [2:0] MODE_SLOPE    = 3'd4;
	localparam logic [2:0] MODE_INTERVAL = 3'd5;
	localparam logic [2:0] MODE_INVERSE  = 3'd6;
	localparam logic [2:0] MODE_NONE     = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOT_ASC  = 2'd3;

	typedef struct packed {
		logic                  start;
		logic signed [OPW-1:0] a;
		logic signed [OPW-1:0] b;
		logic [OPW-1:0]        d;
	} md_req_t;

endpackage

[sv/plcl_if.sv]
// Valid/ready channel interfaces for the curve lookup block.
// Depends on plcl_pkg for the data width.
interface plcl_in_if;
	logic                            valid;
	logic                            ready;
	logic [2:0]                      mode;
	logic signed [plcl_pkg::DW-1:0]  x_value;
	logic signed [plcl_pkg::DW-1:0]  y_value;
	modport source (output valid, mode, x_value, y_value, input ready);
	modport sink (input valid, mode, x_value, y_value, output ready);
endinterface

interface plcl_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [plcl_pkg::DW-1:0]  result_value;
	logic [1:0]                      status;
	modport source (output valid, result_value, status, input ready);
	modport sink (input valid, result_value, status, output ready);
endinterface

[sv/plcl_store.sv]
// Point storage: x and y words, one write port, one registered read port.
// Depends on plcl_pkg for the data width.
module plcl_store #(
	parameter int ENTRIES = plcl_pkg::ENTRIES_DEFAULT
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(ENTRIES)-1:0]     waddr,
	input  logic signed [plcl_pkg::DW-1:0] wx,
	input  logic signed [plcl_pkg::DW-1:0] wy,
	input  logic                           re,
	input  logic [$clog2(ENTRIES)-1:0]     raddr,
	output logic signed [plcl_pkg::DW-1:0] rx,
	output logic signed [plcl_pkg::DW-1:0] ry
);
	logic signed [plcl_pkg::DW-1:0] mem_x [ENTRIES];
	logic signed [plcl_pkg::DW-1:0] mem_y [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rx <= mem_x[raddr];
			ry <= mem_y[raddr];
		end
	end
endmodule

[sv/plcl_muldiv.sv]
// Iterative a*b/d unit: shift-add multiply one bit a cycle, then restoring division.
// Quotient is truncated toward zero with magnitude capped at 2^40. Depends on plcl_pkg.
module plcl_muldiv (
	input  logic                             clk,
	input  logic                             arst_n,
	input  plcl_pkg::md_req_t                req,
	output logic                             done,
	output logic signed [plcl_pkg::QW-1:0]   quo
);
	localparam int W  = plcl_pkg::OPW;
	localparam int PW = 2 * W;
	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MUL  = 2'd1;
	localparam logic [1:0] P_DIV  = 2'd2;
	localparam logic [1:0] P_FIN  = 2'd3;

	logic [1:0]    phase_q;
	logic [6:0]    cnt_q;
	logic [W-1:0]  ua_q, d_q, r_q;
	logic          neg_q;
	logic [PW-1:0] p_q, qt_q;
	logic [W:0]    sum, rs;
	logic          ge;
	logic          over;
	logic [40:0]   mag;

	assign sum = {1'b0, p_q[PW-1:W]} + {1'b0, (p_q[0] ? ua_q : {W{1'b0}})};
	assign rs  = {r_q, p_q[PW-1]};
	assign ge  = rs >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (phase_q)
				P_IDLE: begin
					if (req.start) begin
						phase_q <= P_MUL;
						cnt_q   <= '0;
					end
				end
				P_MUL: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(W - 1)) begin
						phase_q <= P_DIV;
						cnt_q   <= '0;
					end
				end
				P_DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(PW - 1)) phase_q <= P_FIN;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == P_IDLE && req.start) begin
			ua_q  <= req.a[W-1] ? W'(-req.a) : W'(req.a);
			p_q   <= {{W{1'b0}}, (req.b[W-1] ? W'(-req.b) : W'(req.b))};
			d_q   <= req.d;
			neg_q <= req.a[W-1] ^ req.b[W-1];
			r_q   <= '0;
			qt_q  <= '0;
		end else if (phase_q == P_MUL) begin
			p_q <= {sum, p_q[W-1:1]};
		end else if (phase_q == P_DIV) begin
			r_q  <= ge ? W'(rs - {1'b0, d_q}) : W'(rs);
			qt_q <= {qt_q[PW-2:0], ge};
			p_q  <= {p_q[PW-2:0], 1'b0};
		end
	end

	always_comb begin
		over = |qt_q[PW-1:40];
		mag  = over ? {1'b1, 40'd0} : {1'b0, qt_q[39:0]};
		if (d_q == '0) quo = '0;
		else if (neg_q) quo = -$signed({1'b0, mag});
		else quo = $signed({1'b0, mag});
	end

	assign done = phase_q == P_FIN;
endmodule

[sv/piecewise_linear_curve_lookup_top.sv]
// Piecewise-linear curve lookup: a table of ascending (x,y) points with several query modes.
// Clear, load and empty-table items go from dispatch straight to the result; a query first
// scans the stored points (one stored point per cycle through the memory read port), then
// uses the shared multiply-divide unit when interpolation is needed.
// A new item is taken only when the previous one has left for the output register.
// Reset clears the point count and all control state; stored points are undefined until loaded.
module piecewise_linear_curve_lookup_top #(
	parameter int ENTRIES   = plcl_pkg::ENTRIES_DEFAULT,
	parameter int FRAC_BITS = plcl_pkg::FRAC_BITS_DEFAULT
) (
	input logic       clk,
	input logic       arst_n,
	plcl_in_if.sink   item,
	plcl_out_if.source result
);
	localparam int AW  = $clog2(ENTRIES);
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int W   = plcl_pkg::OPW;
	localparam int DW  = plcl_pkg::DW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	// Control and captured item.
	logic [2:0]           state_q;
	logic [2:0]           mode_q;
	logic signed [DW-1:0] xq_q, yq_q;
	logic [CW-1:0]        count_q;
	logic signed [DW-1:0] last_x_q;

	// Scan pipeline: ai_q is the next address to read; di_q tags the point in rx/ry.
	logic [CW-1:0]        ai_q, di_q;
	logic                 dv_q;
	logic signed [DW-1:0] px_q, py_q;
	logic signed [W-1:0]  base_q;
	logic signed [DW-1:0] res_q;
	logic [1:0]           status_q;

	logic                 out_valid_q;
	logic signed [DW-1:0] out_res_q;
	logic [1:0]           out_status_q;

	logic signed [DW-1:0] rx, ry;
	logic                 rd_en, we;
	logic                 load_full, load_nasc;

	plcl_pkg::md_req_t            md_req;
	logic                         md_done;
	logic signed [plcl_pkg::QW-1:0] md_quo;

	// Scan decision signals.
	logic                fin, go_md;
	logic signed [DW-1:0] fin_val;
	logic signed [W-1:0]  base_nx;
	logic signed [W-1:0]  key, ck, cv, pk, pv, cx, cy, px, py, xq;
	logic signed [W-1:0]  dx, n, dy, s, mean, dyc;
	logic                 first, last, le, lt, inv;
	logic signed [W+8:0]  tot;
	logic signed [DW-1:0] sat;

	assign load_full = count_q == CW'(ENTRIES);
	assign load_nasc = count_q != '0 && xq_q <= last_x_q;
	assign we = state_q == S_START && mode_q == plcl_pkg::MODE_LOAD && !load_full && !load_nasc;

	plcl_store #(.ENTRIES(ENTRIES)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wx    (xq_q),
		.wy    (yq_q),
		.re    (rd_en),
		.raddr (ai_q[AW-1:0]),
		.rx    (rx),
		.ry    (ry)
	);

	plcl_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.done   (md_done),
		.quo    (md_quo)
	);

	// Inverse lookup runs the same scan with the roles of x and y swapped.
	always_comb begin
		inv   = mode_q == plcl_pkg::MODE_INVERSE;
		cx    = W'(rx);
		cy    = W'(ry);
		px    = W'(px_q);
		py    = W'(py_q);
		xq    = W'(xq_q);
		key   = inv ? W'(yq_q) : W'(xq_q);
		ck    = inv ? cy : cx;
		cv    = inv ? cx : cy;
		pk    = inv ? py : px;
		pv    = inv ? px : py;
		first = di_q == '0;
		last  = di_q == count_q - CW'(1);
		le    = key <= ck;
		lt    = xq < cx;
		dx    = ck - pk;
		n     = key - pk;
		dy    = cv - pv;
		s     = pv + cv;
		mean  = (s + W'(s < 0)) >>> 1;
		dyc   = (cy - py < 0) ? '0 : cy - py;

		fin     = 1'b0;
		go_md   = 1'b0;
		fin_val = '0;
		base_nx = '0;
		md_req  = '{start: 1'b0, a: '0, b: '0, d: '0};

		if (state_q == S_SCAN && dv_q) begin
			priority if (mode_q == plcl_pkg::MODE_INTERVAL) begin
				if (lt || last) begin
					fin     = 1'b1;
					fin_val = ry;
				end
			end else if (mode_q == plcl_pkg::MODE_SLOPE) begin
				if (!first && le) begin
					go_md    = 1'b1;
					md_req.a = cy - py;
					md_req.b = W'(1) <<< FRAC_BITS;
					md_req.d = W'(cx - px);
				end else if (last) begin
					fin = 1'b1;
				end
			end else begin
				priority if (first && le) begin
					if (mode_q == plcl_pkg::MODE_LOOKUP_X && cx > 0) begin
						go_md    = 1'b1;
						md_req.a = xq;
						md_req.b = cy;
						md_req.d = W'(cx);
					end else begin
						fin     = 1'b1;
						fin_val = DW'(cv);
					end
				end else if (!first && le) begin
					if (dx == '0) begin
						fin     = 1'b1;
						fin_val = DW'(mean);
					end else begin
						go_md    = 1'b1;
						md_req.a = (dx < 0) ? -n : n;
						md_req.b = dy;
						md_req.d = (dx < 0) ? W'(-dx) : W'(dx);
						base_nx  = pv;
					end
				end else if (last) begin
					if (mode_q == plcl_pkg::MODE_LOOKUP_X && !first) begin
						go_md    = 1'b1;
						md_req.a = xq - cx;
						md_req.b = dyc;
						md_req.d = W'(cx - px);
						base_nx  = cy;
					end else begin
						fin     = 1'b1;
						fin_val = DW'(cv);
					end
				end
			end
		end
		md_req.start = go_md;
	end

	assign rd_en = state_q == S_SCAN && !fin && !go_md && ai_q < count_q;

	// Final value: base plus capped quotient, saturated to the 32-bit range.
	always_comb begin
		tot = (W + 9)'(base_q) + (W + 9)'(md_quo);
		if (tot > (W + 9)'(32'sh7FFF_FFFF)) sat = 32'sh7FFF_FFFF;
		else if (tot < -(W + 9)'(64'sh8000_0000)) sat = 32'sh8000_0000;
		else sat = DW'(tot);
	end

	assign item.ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dv_q        <= 1'b0;
			ai_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			dv_q <= rd_en;
			if (rd_en) ai_q <= ai_q + CW'(1);
			if (state_q == S_DONE && (!out_valid_q || result.ready)) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item.valid) state_q <= S_START;
				end
				S_START: begin
					ai_q <= '0;
					priority if (mode_q == plcl_pkg::MODE_CLEAR) begin
						count_q <= '0;
						state_q <= S_DONE;
					end else if (mode_q == plcl_pkg::MODE_LOAD) begin
						if (we) count_q <= count_q + CW'(1);
						state_q <= S_DONE;
					end else if (mode_q == plcl_pkg::MODE_NONE || count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (go_md) state_q <= S_MUL;
					else if (fin) state_q <= S_DONE;
				end
				S_MUL: begin
					if (md_done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			mode_q <= item.mode;
			xq_q   <= item.x_value;
			yq_q   <= item.y_value;
		end
		if (we) last_x_q <= xq_q;
		di_q <= ai_q;
		if (state_q == S_SCAN && dv_q && !fin && !go_md) begin
			px_q <= rx;
			py_q <= ry;
		end
		if (state_q == S_START) begin
			res_q    <= '0;
			status_q <= plcl_pkg::ST_OK;
			if (mode_q == plcl_pkg::MODE_LOAD) begin
				if (load_full) status_q <= plcl_pkg::ST_FULL;
				else if (load_nasc) status_q <= plcl_pkg::ST_NOT_ASC;
			end else if (mode_q != plcl_pkg::MODE_CLEAR && mode_q != plcl_pkg::MODE_NONE
				&& count_q == '0) begin
				status_q <= plcl_pkg::ST_EMPTY;
			end
		end
		if (fin) res_q <= fin_val;
		if (go_md) base_q <= base_nx;
		if (state_q == S_MUL && md_done) res_q <= sat;
		if (state_q == S_DONE && (!out_valid_q || result.ready)) begin
			out_res_q    <= res_q;
			out_status_q <= status_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_value = out_res_q;
	assign result.status       = out_status_q;

	// The table never holds more points than it has room for.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES)) else $error("point count beyond table size");

	// The shared unit only finishes while the sequencer waits for it.
	a_md_done: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> state_q == S_MUL) else $error("divider finished outside wait state");

	// Reads stay below the fill count, so no unwritten entry is used.
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> ai_q < count_q) else $error("read beyond stored points");

	// An accepted item always enters the dispatch state next.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> state_q == S_START) else $error("item not dispatched");

endmodule
